// ----- src/ebzt_pkg.sv -----
package ebzt_pkg;

  // Default datapath sizing
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 8;

  // Field widths
  localparam int SAMPLE_W     = 16;
  localparam int GAIN_W       = 9;
  localparam int DECAY_W      = 16;
  localparam int WARM_W       = 16;
  localparam int Z_W          = 32;
  localparam int BASE_W       = 32;
  localparam int NOISE_W      = 31;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 96;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int DIV_CNT_W    = 5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_GAIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_GAIN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_LENGTH = 2'd3;

  // Register reset values
  localparam logic [GAIN_W-1:0]  FAST_GAIN_RST     = 9'd32;
  localparam logic [GAIN_W-1:0]  SLOW_GAIN_RST     = 9'd3;
  localparam logic [DECAY_W-1:0] DECAY_STEP_RST    = 16'd1;
  localparam logic [WARM_W-1:0]  WARMUP_LENGTH_RST = 16'd64;

  // Multiplier operand select
  localparam logic [1:0] MSEL_FAST  = 2'd0;
  localparam logic [1:0] MSEL_SLOW  = 2'd1;
  localparam logic [1:0] MSEL_NOISE = 2'd2;

  typedef struct packed {
    logic [GAIN_W-1:0]  fast_gain;
    logic [GAIN_W-1:0]  slow_gain;
    logic [DECAY_W-1:0] decay_step;
    logic [WARM_W-1:0]  warmup_length;
  } cfg_t;

  typedef struct packed {
    logic       load_in;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       upd_fast;
    logic       upd_slow;
    logic       upd_base;
    logic       upd_noise;
    logic       div_init;
    logic       div_step;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic dz;
    logic warm;
  } stat_t;

endpackage

// ----- src/ebzt_cfg.sv -----
module ebzt_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ebzt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ebzt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output ebzt_pkg::cfg_t                   cfg
);

  ebzt_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        ebzt_pkg::CFG_FAST_GAIN:     cfg_nxt.fast_gain     = cfg_wdata[ebzt_pkg::GAIN_W-1:0];
        ebzt_pkg::CFG_SLOW_GAIN:     cfg_nxt.slow_gain     = cfg_wdata[ebzt_pkg::GAIN_W-1:0];
        ebzt_pkg::CFG_DECAY_STEP:    cfg_nxt.decay_step    = cfg_wdata[ebzt_pkg::DECAY_W-1:0];
        ebzt_pkg::CFG_WARMUP_LENGTH: cfg_nxt.warmup_length = cfg_wdata[ebzt_pkg::WARM_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fast_gain     <= ebzt_pkg::FAST_GAIN_RST;
      cfg_r.slow_gain     <= ebzt_pkg::SLOW_GAIN_RST;
      cfg_r.decay_step    <= ebzt_pkg::DECAY_STEP_RST;
      cfg_r.warmup_length <= ebzt_pkg::WARMUP_LENGTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/ebzt_ctrl.sv -----
module ebzt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  ebzt_pkg::stat_t stat,
  output ebzt_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_MUL_FAST  = 4'd1;
  localparam logic [3:0] S_MUL_SLOW  = 4'd2;
  localparam logic [3:0] S_UPD_SLOW  = 4'd3;
  localparam logic [3:0] S_BASE      = 4'd4;
  localparam logic [3:0] S_MUL_NOISE = 4'd5;
  localparam logic [3:0] S_UPD_NOISE = 4'd6;
  localparam logic [3:0] S_DIV_INIT  = 4'd7;
  localparam logic [3:0] S_DIV_STEP  = 4'd8;
  localparam logic [3:0] S_WRITE     = 4'd9;

  localparam logic [ebzt_pkg::DIV_CNT_W-1:0] DIV_LAST =
    ebzt_pkg::DIV_CNT_W'(ebzt_pkg::Z_W - 1);

  logic [3:0]                       state_r, state_nxt;
  logic [ebzt_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MUL_FAST;
        end
      end
      S_MUL_FAST: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ebzt_pkg::MSEL_FAST;
        state_nxt   = S_MUL_SLOW;
      end
      S_MUL_SLOW: begin
        cmd.upd_fast = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = ebzt_pkg::MSEL_SLOW;
        state_nxt    = S_UPD_SLOW;
      end
      S_UPD_SLOW: begin
        cmd.upd_slow = 1'b1;
        state_nxt    = S_BASE;
      end
      S_BASE: begin
        cmd.upd_base = 1'b1;
        state_nxt    = stat.dz ? S_MUL_NOISE : S_DIV_INIT;
      end
      S_MUL_NOISE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = ebzt_pkg::MSEL_NOISE;
        state_nxt   = S_UPD_NOISE;
      end
      S_UPD_NOISE: begin
        cmd.upd_noise = 1'b1;
        state_nxt     = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        // no quotient needed until warmup is over
        cmd.div_init = 1'b1;
        cnt_nxt      = DIV_LAST;
        state_nxt    = stat.warm ? S_DIV_STEP : S_WRITE;
      end
      S_DIV_STEP: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)                   out_valid_nxt = 1'b1;
    else if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again right after a request");

  a_out_from_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_WRITE))
    else $error("result shown without passing the write state");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_STEP && cnt_r == '0) |=> (state_r == S_WRITE))
    else $error("divider did not stop after its last step");

endmodule

// ----- src/ebzt_dp.sv -----
module ebzt_dp #(
  parameter int VALUE_WIDTH = ebzt_pkg::VALUE_WIDTH_DEF,
  parameter int FRAC_BITS   = ebzt_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ebzt_pkg::cmd_t                      cmd,
  input  ebzt_pkg::cfg_t                      cfg,
  input  logic signed [ebzt_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_dz,
  output ebzt_pkg::stat_t                     stat,
  output logic [ebzt_pkg::Z_W-1:0]            zscore,
  output logic                                warmed_up,
  output logic [ebzt_pkg::BASE_W-1:0]         baseline_level,
  output logic [ebzt_pkg::NOISE_W-1:0]        noise_level
);

  localparam int VW = VALUE_WIDTH;
  localparam int RW = VALUE_WIDTH + 1;
  localparam int PW = VALUE_WIDTH + ebzt_pkg::GAIN_W + 2;
  localparam int SW = PW + 1;
  localparam int NW = VALUE_WIDTH + 1 + FRAC_BITS;
  localparam int DW = (NW > ebzt_pkg::Z_W) ? NW : ebzt_pkg::Z_W;
  localparam int ZW = ebzt_pkg::Z_W;

  localparam logic signed [VW-1:0] V_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] V_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] V_ONE = VW'(1);
  localparam logic signed [SW-1:0] S_MAX = SW'(V_MAX);
  localparam logic signed [SW-1:0] S_MIN = SW'(V_MIN);
  localparam logic signed [63:0]   L_HI  = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0]   L_LO  = 64'shFFFF_FFFF_8000_0000;
  localparam logic [ZW-1:0]        Z_POS_LIM = {1'b0, {(ZW-1){1'b1}}};
  localparam logic [ZW-1:0]        Z_NEG_LIM = {1'b1, {(ZW-1){1'b0}}};
  localparam logic [ebzt_pkg::WARM_W-1:0] WCNT_MAX = '1;

  function automatic logic signed [VW-1:0] sat_v(input logic signed [SW-1:0] s);
    logic signed [VW-1:0] r;
    if (s > S_MAX)      r = V_MAX;
    else if (s < S_MIN) r = V_MIN;
    else                r = s[VW-1:0];
    return r;
  endfunction

  // avg + (gain * diff >>> FRAC_BITS), product already registered
  function automatic logic signed [VW-1:0] ema_upd(input logic signed [VW-1:0] avg,
                                                    input logic signed [PW-1:0] prod);
    logic signed [PW-1:0] sh;
    logic signed [SW-1:0] sum;
    sh  = prod >>> FRAC_BITS;
    sum = SW'(avg) + SW'(sh);
    return sat_v(sum);
  endfunction

  // architectural state
  logic signed [VW-1:0]          fast_r, fast_nxt;
  logic signed [VW-1:0]          slow_r, slow_nxt;
  logic signed [VW-1:0]          base_r, base_nxt;
  logic signed [VW-1:0]          noise_r, noise_nxt;
  logic                          warm_r, warm_nxt;
  logic [ebzt_pkg::WARM_W-1:0]   wcnt_r, wcnt_nxt;

  // working registers
  logic signed [ebzt_pkg::SAMPLE_W-1:0] x_r, x_nxt;
  logic                          dz_r, dz_nxt;
  logic signed [VW-1:0]          resid_r, resid_nxt;
  logic signed [PW-1:0]          prod_r, prod_nxt;
  logic                          neg_r, neg_nxt;
  logic                          sat_r, sat_nxt;
  logic [RW-1:0]                 rem_r, rem_nxt;
  logic [ZW-1:0]                 dvd_r, dvd_nxt;
  logic [ZW-1:0]                 quo_r, quo_nxt;
  logic [ZW-1:0]                 z_r, z_nxt;
  logic                          wo_r, wo_nxt;
  logic [ebzt_pkg::BASE_W-1:0]   bo_r, bo_nxt;
  logic [ebzt_pkg::NOISE_W-1:0]  no_r, no_nxt;

  // shared multiplier
  logic signed [VW-1:0]          x_ext;
  logic signed [VW-1:0]          m_tgt, m_avg;
  logic [ebzt_pkg::GAIN_W-1:0]   m_gain;
  logic signed [ebzt_pkg::GAIN_W:0] m_gain_s;
  logic signed [VW:0]            m_diff;
  logic signed [PW-1:0]          m_prod;

  // baseline / residual
  logic [ebzt_pkg::WARM_W-1:0]   wcnt_inc;
  logic                          seed;
  logic                          warm_new;
  logic signed [VW-1:0]          base_pre;
  logic signed [VW:0]            b_dec;
  logic signed [VW:0]            r_diff, r_abs;
  logic signed [VW-1:0]          n_upd;

  // divider
  logic signed [VW:0]            num;
  logic [VW:0]                   mag;
  logic [DW-1:0]                 n_full, d_hi, d_sor;
  logic [RW-1:0]                 r_sh, r_dsr;
  logic                          r_ge;
  logic [ZW-1:0]                 z_lim, z_res, z_sgn;
  logic signed [63:0]            b64, n64;

  assign x_ext = VW'(x_r);

  always_comb begin
    case (cmd.mul_sel)
      ebzt_pkg::MSEL_FAST:  begin m_tgt = x_ext;   m_avg = fast_r;  m_gain = cfg.fast_gain; end
      ebzt_pkg::MSEL_SLOW:  begin m_tgt = x_ext;   m_avg = slow_r;  m_gain = cfg.slow_gain; end
      ebzt_pkg::MSEL_NOISE: begin m_tgt = resid_r; m_avg = noise_r; m_gain = cfg.slow_gain; end
      default:              begin m_tgt = x_ext;   m_avg = fast_r;  m_gain = cfg.fast_gain; end
    endcase
  end

  assign m_gain_s = $signed({1'b0, m_gain});
  assign m_diff   = RW'(m_tgt) - RW'(m_avg);
  assign m_prod   = m_gain_s * m_diff;

  // warmup count and baseline tracking, on the freshly updated slow EMA
  assign wcnt_inc = (wcnt_r != WCNT_MAX) ? wcnt_r + 1'b1 : wcnt_r;
  assign seed     = !warm_r && (wcnt_inc >= cfg.warmup_length);
  assign warm_new = warm_r || seed;
  assign base_pre = seed ? slow_r : base_r;
  assign b_dec    = RW'(base_pre) - RW'($signed({1'b0, cfg.decay_step}));
  assign r_diff   = RW'(x_ext) - RW'(slow_r);
  assign r_abs    = r_diff[VW] ? -r_diff : r_diff;
  assign n_upd    = ema_upd(noise_r, prod_r);

  // dividend = |baseline - slow| << FRAC_BITS; the part above the quotient
  // bits must stay below the divisor or the result saturates
  assign num    = RW'(base_r) - RW'(slow_r);
  assign mag    = num[VW] ? $unsigned(-num) : $unsigned(num);
  assign n_full = DW'(mag) << FRAC_BITS;
  assign d_hi   = n_full >> ZW;
  assign d_sor  = DW'($unsigned(noise_r));

  assign r_sh   = {rem_r[RW-2:0], dvd_r[ZW-1]};
  assign r_dsr  = RW'($unsigned(noise_r));
  assign r_ge   = (r_sh >= r_dsr);

  assign z_lim  = neg_r ? Z_NEG_LIM : Z_POS_LIM;
  assign z_res  = (sat_r || (quo_r > z_lim)) ? z_lim : quo_r;
  assign z_sgn  = neg_r ? (~z_res + 1'b1) : z_res;
  assign b64    = 64'(base_r);
  assign n64    = 64'(noise_r);

  always_comb begin
    fast_nxt  = fast_r;
    slow_nxt  = slow_r;
    base_nxt  = base_r;
    noise_nxt = noise_r;
    warm_nxt  = warm_r;
    wcnt_nxt  = wcnt_r;
    x_nxt     = x_r;
    dz_nxt    = dz_r;
    resid_nxt = resid_r;
    prod_nxt  = prod_r;
    neg_nxt   = neg_r;
    sat_nxt   = sat_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    quo_nxt   = quo_r;
    z_nxt     = z_r;
    wo_nxt    = wo_r;
    bo_nxt    = bo_r;
    no_nxt    = no_r;

    if (cmd.load_in) begin
      x_nxt  = in_sample;
      dz_nxt = in_dz;
    end
    if (cmd.mul_en)   prod_nxt = m_prod;
    if (cmd.upd_fast) fast_nxt = ema_upd(fast_r, prod_r);
    if (cmd.upd_slow) slow_nxt = ema_upd(slow_r, prod_r);
    if (cmd.upd_base) begin
      warm_nxt  = warm_new;
      if (!warm_r) wcnt_nxt = wcnt_inc;
      if (warm_new) base_nxt = (slow_r > base_pre) ? slow_r : sat_v(SW'(b_dec));
      resid_nxt = sat_v(SW'(r_abs));
    end
    if (cmd.upd_noise) noise_nxt = (n_upd < V_ONE) ? V_ONE : n_upd;
    if (cmd.div_init) begin
      neg_nxt = num[VW];
      sat_nxt = (d_hi >= d_sor);
      rem_nxt = d_hi[RW-1:0];
      dvd_nxt = n_full[ZW-1:0];
      quo_nxt = '0;
    end
    if (cmd.div_step) begin
      rem_nxt = r_ge ? (r_sh - r_dsr) : r_sh;
      quo_nxt = {quo_r[ZW-2:0], r_ge};
      dvd_nxt = {dvd_r[ZW-2:0], 1'b0};
    end
    if (cmd.out_load) begin
      z_nxt  = warm_r ? z_sgn : Z_POS_LIM;
      wo_nxt = warm_r;
      if (b64 > L_HI)      bo_nxt = Z_POS_LIM;
      else if (b64 < L_LO) bo_nxt = Z_NEG_LIM;
      else                 bo_nxt = b64[ebzt_pkg::BASE_W-1:0];
      no_nxt = (n64 > L_HI) ? '1 : n64[ebzt_pkg::NOISE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_r  <= '0;
      slow_r  <= '0;
      base_r  <= '0;
      noise_r <= V_ONE;
      warm_r  <= 1'b0;
      wcnt_r  <= '0;
    end else begin
      fast_r  <= fast_nxt;
      slow_r  <= slow_nxt;
      base_r  <= base_nxt;
      noise_r <= noise_nxt;
      warm_r  <= warm_nxt;
      wcnt_r  <= wcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    dz_r    <= dz_nxt;
    resid_r <= resid_nxt;
    prod_r  <= prod_nxt;
    neg_r   <= neg_nxt;
    sat_r   <= sat_nxt;
    rem_r   <= rem_nxt;
    dvd_r   <= dvd_nxt;
    quo_r   <= quo_nxt;
    z_r     <= z_nxt;
    wo_r    <= wo_nxt;
    bo_r    <= bo_nxt;
    no_r    <= no_nxt;
  end

  assign stat.dz        = dz_r;
  assign stat.warm      = warm_r;
  assign zscore         = z_r;
  assign warmed_up      = wo_r;
  assign baseline_level = bo_r;
  assign noise_level    = no_r;

  a_noise_floor: assert property (@(posedge clk) disable iff (!rst_n)
    noise_r >= V_ONE)
    else $error("noise estimate fell below one");

  a_warm_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    warm_r |=> warm_r)
    else $error("warm flag dropped without reset");

endmodule

// ----- src/ema_baseline_zscore_tracker_unit.sv -----
// A request runs the multiply, slow update and baseline states, then the noise
//   update if the dead-zone flag is set and the radix-2 divider once warmed up.
// A new request is taken only after the last result is loaded for output, which
//   waits on out_tready; the divider and the shared multiplier set the pace.
// Reset (rst_n low, synchronous) clears the averages, baseline, warm flag and
//   warmup count, sets noise to one and restores the register defaults.
module ema_baseline_zscore_tracker_unit #(
  parameter int VALUE_WIDTH = ebzt_pkg::VALUE_WIDTH_DEF,
  parameter int FRAC_BITS   = ebzt_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ebzt_pkg::IN_TDATA_W-1:0]    in_tdata,   // [15:0] sample
  input  logic                               in_tuser,   // in_deadzone
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] zscore, [63:32] baseline_level, [94:64] noise_level, [95] zero
  output logic [ebzt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tuser,  // warmed_up
  input  logic                               cfg_we,
  input  logic [ebzt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ebzt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  ebzt_pkg::cfg_t  cfg;
  ebzt_pkg::cmd_t  cmd;
  ebzt_pkg::stat_t stat;

  logic [ebzt_pkg::Z_W-1:0]     zscore;
  logic [ebzt_pkg::BASE_W-1:0]  baseline_level;
  logic [ebzt_pkg::NOISE_W-1:0] noise_level;
  logic                         warmed_up;

  ebzt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ebzt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ebzt_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg            (cfg),
    .in_sample      ($signed(in_tdata[ebzt_pkg::SAMPLE_W-1:0])),
    .in_dz          (in_tuser),
    .stat           (stat),
    .zscore         (zscore),
    .warmed_up      (warmed_up),
    .baseline_level (baseline_level),
    .noise_level    (noise_level)
  );

  assign out_tdata = {1'b0, noise_level, baseline_level, zscore};
  assign out_tuser = warmed_up;

endmodule
